FILE: hw/rtl/lpc_pkg.sv
// Shared widths and defaults for the LRU paging cache.
package lpc_pkg;

  localparam int WAYS_DEF = 16;
  localparam int PAGE_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 32;
  localparam int SLOT_W   = 4;

endpackage

FILE: hw/rtl/lpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lru_paging_cache_core.sv
// Top level of the fully associative LRU page cache.
//
// Input channel: one beat carries one page number (in_valid / in_stall).
// Result channel: one beat per input carrying the hit flag, the slot that was
// refreshed or filled, and the running hit and miss totals (out_valid /
// out_stall).
// Each reference sweeps the tag/timestamp RAM one entry per cycle, finding
// the first matching tag and the first entry with the smallest stamp below
// the current tick in the same pass, then writes the chosen entry back.
// An item goes from accept through the sweep of the single RAM read port to
// the write-back and the result; a new page is accepted the cycle after the
// result is loaded into the output register, so the block does not take a
// new page before it is through with the last one.
// Reset clears the totals, the tick and the per-entry valid bits at once; an
// entry without its valid bit reads as tag zero and stamp zero, so page zero
// hits in slot zero after reset. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register; the
// block keeps taking one more page and holds its write-back until the output
// register frees up.
module lru_paging_cache_core
  import lpc_pkg::*;
#(
  parameter int WAYS = WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PAGE_W-1:0]   in_page_number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [CNT_W-1:0]    out_hit_count,
  output logic [CNT_W-1:0]    out_miss_count
);

  localparam int IW     = $clog2(WAYS);
  localparam int ENTRY_W = PAGE_W + STAMP_W;
  localparam logic [IW-1:0] LAST = IW'(WAYS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t              state_r;
  logic [PAGE_W-1:0]   page_r;
  logic [STAMP_W-1:0]  tick_r;
  logic [CNT_W-1:0]    hits_r;
  logic [CNT_W-1:0]    misses_r;
  logic [WAYS-1:0]     valid_r;
  logic [IW-1:0]       rd_idx_r;
  logic                issue_r;
  logic                ev_vld_r;
  logic [IW-1:0]       ev_idx_r;
  logic                found_r;
  logic [IW-1:0]       where_r;
  logic [STAMP_W-1:0]  oldest_r;
  logic [IW-1:0]       victim_r;
  logic                out_valid_r;
  logic                out_hit_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [ENTRY_W-1:0]  rd_data;
  logic [PAGE_W-1:0]   ev_tag;
  logic [STAMP_W-1:0]  ev_stamp;
  logic                out_free;
  logic                commit;
  logic [IW-1:0]       wr_slot;
  logic                rd_en;

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_WRITE) && out_free;
  assign wr_slot  = found_r ? where_r : victim_r;
  assign rd_en    = (state_r == S_SCAN) && issue_r;
  assign ev_tag   = valid_r[ev_idx_r] ? rd_data[ENTRY_W-1:STAMP_W] : '0;
  assign ev_stamp = valid_r[ev_idx_r] ? rd_data[STAMP_W-1:0] : '0;

  lpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WAYS)
  ) u_entries (
    .clk  (clk),
    .we   (commit),
    .waddr(wr_slot),
    .wdata({page_r, tick_r}),
    .re   (rd_en),
    .raddr(rd_idx_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            page_r   <= in_page_number;
            tick_r   <= tick_r + 1'b1;
            oldest_r <= tick_r + 1'b1;
            found_r  <= 1'b0;
            where_r  <= '0;
            victim_r <= '0;
            rd_idx_r <= '0;
            issue_r  <= 1'b1;
            ev_vld_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          ev_vld_r <= issue_r;
          ev_idx_r <= rd_idx_r;
          if (issue_r) begin
            if (rd_idx_r == LAST) begin
              issue_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          if (ev_vld_r) begin
            if (!found_r && ev_tag == page_r) begin
              found_r <= 1'b1;
              where_r <= ev_idx_r;
            end
            if (ev_stamp < oldest_r) begin
              oldest_r <= ev_stamp;
              victim_r <= ev_idx_r;
            end
            if (ev_idx_r == LAST) begin
              state_r  <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            valid_r[wr_slot] <= 1'b1;
            if (found_r) begin
              hits_r <= hits_r + 1'b1;
            end else begin
              misses_r <= misses_r + 1'b1;
            end
            out_hit_r   <= found_r;
            out_slot_r  <= SLOT_W'(wr_slot);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot       = out_slot_r;
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

  a_one_count_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (hits_r + misses_r) == ($past(hits_r) + $past(misses_r) + 1'b1))
    else $error("totals did not advance by one per item");

  a_eval_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> state_r == S_SCAN)
    else $error("entry evaluated outside the sweep");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> oldest_r <= tick_r)
    else $error("victim stamp above current tick");

  a_result_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && state_r == S_IDLE)
    else $error("write-back without a result beat");

endmodule

FILE: dv/tb_lru_paging_cache_core.sv
`timescale 1ns / 100ps
// Testbench for lru_paging_cache_core: directed and random page references checked against an LRU predictor.
module tb_lru_paging_cache_core;
  import lpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int REPORT_MAX     = 10;
  localparam int POOL_MAX       = 24;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } page_lookup_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_hit_count;
  logic [CNT_W-1:0]  out_miss_count;

  logic [PAGE_W-1:0]  resident_page [WAYS_DEF];
  logic [STAMP_W-1:0] last_touch [WAYS_DEF];
  logic [STAMP_W-1:0] ref_clock;
  logic [CNT_W-1:0]   hit_total;
  logic [CNT_W-1:0]   miss_total;

  page_lookup_t      pending_results[$];
  logic [PAGE_W-1:0] hot_pages [POOL_MAX];
  bit                idling_on = 1'b1;
  int                fail_count = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  lru_paging_cache_core #(.WAYS(WAYS_DEF)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_page_number(in_page_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_slot      (out_slot),
    .out_hit_count (out_hit_count),
    .out_miss_count(out_miss_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_cache_model();
    for (int i = 0; i < WAYS_DEF; i++) begin
      resident_page[i] = '0;
      last_touch[i] = '0;
    end
    ref_clock = '0;
    hit_total = '0;
    miss_total = '0;
  endfunction

  function automatic page_lookup_t lookup_page(logic [PAGE_W-1:0] pg);
    page_lookup_t      res;
    bit                found;
    int                way;
    logic [STAMP_W-1:0] oldest;
    found = 1'b0;
    way = 0;
    ref_clock = ref_clock + 1'b1;
    for (int i = 0; i < WAYS_DEF; i++) begin
      if (!found && resident_page[i] == pg) begin
        found = 1'b1;
        way = i;
      end
    end
    if (found) begin
      hit_total = hit_total + 1'b1;
    end else begin
      miss_total = miss_total + 1'b1;
      oldest = ref_clock;
      for (int i = 0; i < WAYS_DEF; i++) begin
        if (last_touch[i] < oldest) begin
          oldest = last_touch[i];
          way = i;
        end
      end
      resident_page[way] = pg;
    end
    last_touch[way] = ref_clock;
    res.hit = found;
    res.slot = way[SLOT_W-1:0];
    res.hits = hit_total;
    res.misses = miss_total;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page_number <= pg;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(lookup_page(pg));
  endtask

  task automatic log_failure(input string what, input page_lookup_t exp_r,
                             input page_lookup_t got_r);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s expected hit=%0b slot=%0d hits=%0d misses=%0d", $realtime, what,
               exp_r.hit, exp_r.slot, exp_r.hits, exp_r.misses);
      $display("%0t: %s actual   hit=%0b slot=%0d hits=%0d misses=%0d", $realtime, what,
               got_r.hit, got_r.slot, got_r.hits, got_r.misses);
    end
  endtask

  always @(posedge clk) begin
    page_lookup_t got_r;
    page_lookup_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_r = '{out_hit, out_slot, out_hit_count, out_miss_count};
        if (pending_results.size() == 0) begin
          log_failure("unexpected beat", '0, got_r);
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r.hit !== exp_r.hit || got_r.slot !== exp_r.slot ||
              got_r.hits !== exp_r.hits || got_r.misses !== exp_r.misses)
            log_failure("result mismatch", exp_r, got_r);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idling_on) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: stall_left = $urandom_range(1, 3);
            4:          stall_left = $urandom_range(10, 40);
            default:    stall_left = 0;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_page_zero_after_reset();
    send_page(32'h0000_0000);
    send_page(32'h0000_0000);
  endtask

  task automatic test_duplicate_zero_tags();
    send_page(32'hFFFF_FFFF);
    send_page(32'h0000_0000);
    send_page(32'hFFFF_FFFF);
  endtask

  task automatic test_fill_and_evict();
    for (int i = 0; i < 14; i++) send_page(32'h0000_0100 + i);
    send_page(32'h0000_0103);
    send_page(32'h0000_0100);
    send_page(32'h0000_0000);
  endtask

  task automatic test_extreme_pages();
    send_page(32'h8000_0000);
    send_page(32'h0000_0001);
    send_page(32'h7FFF_FFFE);
    send_page(32'h8000_0000);
  endtask

  task automatic test_random_references(input int n_items, input bit with_idling);
    int                pool_n;
    int                r;
    logic [PAGE_W-1:0] pg;
    idling_on = with_idling;
    pool_n = $urandom_range(10, POOL_MAX);
    for (int i = 0; i < POOL_MAX; i++)
      hot_pages[i] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        pg = hot_pages[$urandom_range(0, pool_n - 1)];
      else if (r < 90)
        pg = $urandom;
      else if (r < 95)
        pg = 32'h1 << $urandom_range(0, 31);
      else
        pg = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      send_page(pg);
    end
  endtask

  initial begin
    clear_cache_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_page_zero_after_reset();
    test_duplicate_zero_tags();
    test_fill_and_evict();
    test_extreme_pages();
    test_random_references(150, 1'b1);
    test_random_references(100, 1'b0);
    test_random_references(175, 1'b1);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
